[rtl/nfp_pkg.sv]
// ----------------------------------------------------------------------------
// nfp_pkg
// Shared widths, constants, tables and fixed-point helpers of the Newton
// fractal pixel unit (signed Q8.24 with saturation).
// ----------------------------------------------------------------------------
`default_nettype none
package nfp_pkg;

    // number format
    localparam int IB = 12;                 // pixel index bits
    localparam int FB = 24;                 // fraction bits
    localparam int XW = 32;                 // coordinate width
    localparam int SW = 27;                 // pixel step width
    localparam int PW = 2 * XW;             // product width
    localparam int NW = XW - 1 + FB;        // reciprocal numerator / quotient width
    localparam int DW = 2 * (XW - 1) + 1;   // squared magnitude width
    localparam int MW = IB + SW + 2;        // pixel mapping sum width
    localparam int NB = FB - 9;             // a difference at or above 2^NB is never near
    localparam int AW = 2 * NB + 1;         // squared distance width when near

    localparam logic [XW-1:0]        LIM    = {1'b0, {(XW-1){1'b1}}};
    localparam logic signed [XW-1:0] ONE    = XW'(64'd1 << FB);
    localparam logic signed [MW-1:0] TWO_M  = MW'(64'd1 << (FB + 1));
    localparam logic [AW-1:0]        NEAR_T = AW'((64'd1 << (2 * FB)) / 64'd1000000);

    // degree codes
    localparam logic [3:0] DEG_2 = 4'd2;
    localparam logic [3:0] DEG_3 = 4'd3;
    localparam logic [3:0] DEG_5 = 4'd5;
    localparam logic [3:0] DEG_7 = 4'd7;

    // register indexes
    localparam logic [2:0] REG_DEGREE = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_CAP    = 3'd2;
    localparam logic [2:0] REG_ESCAPE = 3'd3;

    typedef enum logic [2:0] {
        RSN_ROOT   = 3'd0,
        RSN_ORIGIN = 3'd1,
        RSN_ESCAPE = 3'd2,
        RSN_CAP    = 3'd3,
        RSN_DEGREE = 3'd4
    } t_reason;

    typedef struct packed {
        logic                  ovf;
        logic signed [XW-1:0]  v;
    } t_fix;

    // roots of unity for degree 3, then 5, then 7 (rounded to Q8.24)
    localparam logic signed [XW-1:0] ROOT_RE [0:14] = '{
        32'sd16777216, -32'sd8388608, -32'sd8388608,
        32'sd16777216, 32'sd5184445, -32'sd13573053, -32'sd13573053, 32'sd5184445,
        32'sd16777216, 32'sd10460423, -32'sd3733282, -32'sd15115749,
        -32'sd15115749, -32'sd3733282, 32'sd10460423
    };
    localparam logic signed [XW-1:0] ROOT_IM [0:14] = '{
        32'sd0, 32'sd14529495, -32'sd14529495,
        32'sd0, 32'sd15956081, 32'sd9861400, -32'sd9861400, -32'sd15956081,
        32'sd0, 32'sd13116956, 32'sd16356576, 32'sd7279361,
        -32'sd7279361, -32'sd16356576, -32'sd13116956
    };

    function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
        logic [XW-1:0] r;
        r = v[XW-1] ? XW'(-v) : XW'(v);
        return r;
    endfunction

    // saturating sum
    function automatic t_fix sat_add(input logic signed [XW-1:0] a,
                                     input logic signed [XW-1:0] b);
        logic signed [XW:0] s;
        logic signed [XW:0] lims;
        t_fix r;
        lims = $signed({1'b0, LIM});
        s = $signed({a[XW-1], a}) + $signed({b[XW-1], b});
        r.ovf = 1'b0;
        r.v = XW'(s);
        if (s > lims) begin
            r.ovf = 1'b1;
            r.v = $signed(LIM);
        end else if (s < -lims) begin
            r.ovf = 1'b1;
            r.v = -$signed(LIM);
        end
        return r;
    endfunction

    // magnitude to signed value with saturation
    function automatic t_fix fix_mag(input logic [NW-1:0] m, input logic neg);
        logic [XW-1:0] u;
        t_fix r;
        r.ovf = 1'b0;
        u = m[XW-1:0];
        if (m > NW'(LIM)) begin
            r.ovf = 1'b1;
            u = LIM;
        end
        r.v = neg ? -$signed(u) : $signed(u);
        return r;
    endfunction

    // pixel mapping clamp
    function automatic t_fix clamp_map(input logic signed [MW-1:0] s);
        logic signed [MW-1:0] lims;
        t_fix r;
        lims = MW'($signed({1'b0, LIM}));
        r.ovf = 1'b0;
        r.v = XW'(s);
        if (s > lims) begin
            r.ovf = 1'b1;
            r.v = $signed(LIM);
        end else if (s < -lims) begin
            r.ovf = 1'b1;
            r.v = -$signed(LIM);
        end
        return r;
    endfunction

    // reciprocal of the degree, scaled for the shift in div_small
    function automatic logic [XW-1:0] recip(input logic [3:0] d);
        logic [XW-1:0] r;
        case (d)
            DEG_2:   r = 32'h8000_0000;
            DEG_3:   r = 32'd2863311531;
            DEG_5:   r = 32'd3435973837;
            DEG_7:   r = 32'd2454267027;
            default: r = '0;
        endcase
        return r;
    endfunction

    // floor(m / d) from the product m * recip(d)
    function automatic logic [XW-1:0] div_small(input logic [PW-1:0] p, input logic [3:0] d);
        logic [XW-1:0] r;
        case (d)
            DEG_2:   r = XW'(p >> 32);
            DEG_3:   r = XW'(p >> 33);
            DEG_5:   r = XW'(p >> 34);
            DEG_7:   r = XW'(p >> 34);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [XW-1:0] times_small(input logic [XW-1:0] q,
                                                  input logic [2:0] d);
        logic [XW-1:0] r;
        r = (d[0] ? q : '0) + (d[1] ? (q << 1) : '0) + (d[2] ? (q << 2) : '0);
        return r;
    endfunction

    // v*(d-1)/d when rest is set, else v/d, truncated toward zero
    function automatic logic signed [XW-1:0] frac_scale(input logic signed [XW-1:0] v,
                                                        input logic [PW-1:0] p,
                                                        input logic [3:0] d,
                                                        input logic rest);
        logic [XW-1:0] m;
        logic [XW-1:0] q;
        logic [XW-1:0] c;
        logic [XW-1:0] r;
        m = mag(v);
        q = div_small(p, d);
        c = q + XW'(times_small(q, d[2:0]) != m);
        r = rest ? (m - c) : q;
        return v[XW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [3:0] root_base(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            DEG_5:   r = 4'd3;
            DEG_7:   r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // test point idx: roots first, then the origin at idx == d
    function automatic logic signed [XW-1:0] point_re(input logic [3:0] d,
                                                      input logic [2:0] idx);
        logic signed [XW-1:0] r;
        if (idx == d[2:0]) begin
            r = '0;
        end else if (d == DEG_2) begin
            r = (idx == 3'd0) ? ONE : -ONE;
        end else begin
            r = ROOT_RE[root_base(d) + {1'b0, idx}];
        end
        return r;
    endfunction

    function automatic logic signed [XW-1:0] point_im(input logic [3:0] d,
                                                      input logic [2:0] idx);
        logic signed [XW-1:0] r;
        if (idx == d[2:0] || d == DEG_2) begin
            r = '0;
        end else begin
            r = ROOT_IM[root_base(d) + {1'b0, idx}];
        end
        return r;
    endfunction

    function automatic logic [7:0] gray_of(input logic [15:0] it, input logic [3:0] d);
        logic [7:0] lo;
        if (d == DEG_3 || d == DEG_7) begin
            lo = {it[4:0], 3'b000} + {it[6:0], 1'b0};
        end else begin
            lo = it[7:0];
        end
        return (lo == 8'hFF) ? 8'h00 : lo;
    endfunction

endpackage
`default_nettype wire

[rtl/newton_fractal_pixel_unit.sv]
// ----------------------------------------------------------------------------
// newton_fractal_pixel_unit
// Newton fractal pixel for x^d - 1: maps a pixel, iterates, returns gray level.
// ----------------------------------------------------------------------------
// One pixel at a time: start is taken while busy is low, and busy stays high
// until the result is out. The result appears for one cycle with o_valid and
// must be taken then. Each Newton step runs two 55-bit reciprocal quotients
// through the bit-serial divider, plus 4*(d-2) + 6 passes through the
// shared multiplier; a zero power skips both quotients. Each convergence
// test visits the roots in turn and then the origin. An unsupported degree
// is answered in the cycle after start, with no iteration. Configuration
// must be written only while busy is low; the block itself does not enforce it.
`default_nettype none
module newton_fractal_pixel_unit import nfp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [IB-1:0] i_row,
    input  wire logic [IB-1:0] i_column,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [30:0]   i_cfg_data,
    output logic               o_valid,
    output logic [7:0]         o_gray,
    output logic [15:0]        o_iterations,
    output logic [2:0]         o_stop_reason
);

    typedef enum logic [21:0] {
        ST_IDLE  = 22'h000001,
        ST_MAPX  = 22'h000002,
        ST_MAPY  = 22'h000004,
        ST_STEP  = 22'h000008,
        ST_CM0   = 22'h000010,
        ST_CM1   = 22'h000020,
        ST_CM2   = 22'h000040,
        ST_CM3   = 22'h000080,
        ST_CM4   = 22'h000100,
        ST_NORM0 = 22'h000200,
        ST_NORM1 = 22'h000400,
        ST_NORM2 = 22'h000800,
        ST_DIVR  = 22'h001000,
        ST_DIVI  = 22'h002000,
        ST_SC0   = 22'h004000,
        ST_SC1   = 22'h008000,
        ST_SC2   = 22'h010000,
        ST_SC3   = 22'h020000,
        ST_SC4   = 22'h040000,
        ST_TEST0 = 22'h080000,
        ST_TEST1 = 22'h100000,
        ST_TEST2 = 22'h200000
    } t_state;

    // configuration
    logic [3:0]  r_degree;
    logic [SW-1:0] r_step;
    logic [15:0] r_cap;
    logic [30:0] r_esc;

    // control
    t_state r_state, n_state;
    logic   r_ovf, n_ovf;
    logic   r_inc, n_inc;
    logic [15:0] r_iter, n_iter;
    logic [2:0]  r_k, n_k;
    logic [2:0]  r_pt, n_pt;
    logic        r_valid, n_valid;

    // datapath
    logic [IB-1:0]        r_row, n_row;
    logic signed [XW-1:0] r_xr, n_xr, r_xi, n_xi, r_pr, n_pr, r_pi, n_pi;
    logic signed [XW-1:0] r_f0, n_f0, r_f1, n_f1, r_f2, n_f2;
    logic signed [XW-1:0] r_qr, n_qr, r_qi, n_qi, r_t, n_t;
    logic [DW-1:0]        r_n, n_n;
    logic [AW-1:0]        r_acc, n_acc;
    logic [7:0]           r_gray, n_gray;
    logic [15:0]          r_iters, n_iters;
    t_reason              r_reason, n_reason;

    // shared units
    logic [XW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    // helpers
    logic [XW-1:0] mr, mi, dr, di;
    logic [XW-1:0] magic;
    logic [DW-1:0] n_sum;
    logic [AW:0]   d2;
    t_fix          dsum_r, dsum_i;
    logic          supported;

    assign mr        = mag(r_pr);
    assign mi        = mag(r_pi);
    assign magic     = recip(r_degree);
    assign dsum_r    = sat_add(r_xr, -point_re(r_degree, r_pt));
    assign dsum_i    = sat_add(r_xi, -point_im(r_degree, r_pt));
    assign dr        = mag(dsum_r.v);
    assign di        = mag(dsum_i.v);
    assign n_sum     = r_n + mul_p[DW-1:0];
    assign d2        = {1'b0, r_acc} + {1'b0, mul_p[AW-1:0]};
    assign supported = (r_degree == DEG_2) || (r_degree == DEG_3) ||
                       (r_degree == DEG_5) || (r_degree == DEG_7);

    nfp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    nfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_IDLE: begin
                mul_a = XW'({i_column, 1'b1});
                mul_b = XW'(r_step);
            end
            ST_MAPX: begin
                mul_a = XW'({r_row, 1'b1});
                mul_b = XW'(r_step);
            end
            ST_CM0:   begin mul_a = mr;        mul_b = mag(r_xr); end
            ST_CM1:   begin mul_a = mi;        mul_b = mag(r_xi); end
            ST_CM2:   begin mul_a = mr;        mul_b = mag(r_xi); end
            ST_CM3:   begin mul_a = mi;        mul_b = mag(r_xr); end
            ST_NORM0: begin mul_a = mr;        mul_b = mr;        end
            ST_NORM1: begin mul_a = mi;        mul_b = mi;        end
            ST_SC0:   begin mul_a = mag(r_xr); mul_b = magic;     end
            ST_SC1:   begin mul_a = mag(r_qr); mul_b = magic;     end
            ST_SC2:   begin mul_a = mag(r_xi); mul_b = magic;     end
            ST_SC3:   begin mul_a = mag(r_qi); mul_b = magic;     end
            ST_TEST0: begin mul_a = dr;        mul_b = dr;        end
            ST_TEST1: begin mul_a = di;        mul_b = di;        end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        t_fix          fa;
        t_fix          fb;
        t_fix          fc;
        logic          fin;
        t_reason       fin_reason;
        logic [15:0]   fin_iter;
        logic          adv;
        logic [IB+SW-1:0] mv;

        n_state  = r_state;
        n_ovf    = r_ovf;
        n_inc    = r_inc;
        n_iter   = r_iter;
        n_k      = r_k;
        n_pt     = r_pt;
        n_valid  = 1'b0;
        n_row    = r_row;
        n_xr     = r_xr;
        n_xi     = r_xi;
        n_pr     = r_pr;
        n_pi     = r_pi;
        n_f0     = r_f0;
        n_f1     = r_f1;
        n_f2     = r_f2;
        n_qr     = r_qr;
        n_qi     = r_qi;
        n_t      = r_t;
        n_n      = r_n;
        n_acc    = r_acc;
        n_gray   = r_gray;
        n_iters  = r_iters;
        n_reason = r_reason;
        div_start = 1'b0;
        div_num   = {mr[XW-2:0], {FB{1'b0}}};
        div_den   = n_sum;
        fin        = 1'b0;
        fin_reason = RSN_ROOT;
        fin_iter   = r_iter;
        adv        = 1'b0;
        mv         = mul_p[IB+SW:1];
        fa         = '0;
        fb         = '0;
        fc         = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_row = i_row;
                    if (!supported) begin
                        fin        = 1'b1;
                        fin_reason = RSN_DEGREE;
                        fin_iter   = '0;
                    end else begin
                        n_iter  = '0;
                        n_ovf   = 1'b0;
                        n_inc   = 1'b0;
                        n_state = ST_MAPX;
                    end
                end
            end
            // pixel to complex point
            ST_MAPX: begin
                fa      = clamp_map($signed({2'b00, mv}) - TWO_M);
                n_xr    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_MAPY;
            end
            ST_MAPY: begin
                fa      = clamp_map(TWO_M - $signed({2'b00, mv}));
                n_xi    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_STEP;
            end
            // newton step: power x^(d-1)
            ST_STEP: begin
                n_pr    = r_xr;
                n_pi    = r_xi;
                n_k     = r_degree[2:0] - 3'd2;
                n_state = (r_degree == DEG_2) ? ST_NORM0 : ST_CM0;
            end
            ST_CM0: n_state = ST_CM1;
            ST_CM1: begin
                fa      = fix_mag(NW'(mul_p >> FB), r_pr[XW-1] ^ r_xr[XW-1]);
                n_f0    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_CM2;
            end
            ST_CM2: begin
                fa      = fix_mag(NW'(mul_p >> FB), r_pi[XW-1] ^ r_xi[XW-1]);
                n_f1    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_CM3;
            end
            ST_CM3: begin
                fa      = fix_mag(NW'(mul_p >> FB), r_pr[XW-1] ^ r_xi[XW-1]);
                n_f2    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_CM4;
            end
            ST_CM4: begin
                fa    = fix_mag(NW'(mul_p >> FB), r_pi[XW-1] ^ r_xr[XW-1]);
                fb    = sat_add(r_f0, -r_f1);
                fc    = sat_add(r_f2, fa.v);
                n_pr  = fb.v;
                n_pi  = fc.v;
                n_ovf = r_ovf | fa.ovf | fb.ovf | fc.ovf;
                if (r_k == 3'd1) begin
                    n_state = ST_NORM0;
                end else begin
                    n_k     = r_k - 3'd1;
                    n_state = ST_CM0;
                end
            end
            // reciprocal of the power
            ST_NORM0: n_state = ST_NORM1;
            ST_NORM1: begin
                n_n     = mul_p[DW-1:0];
                n_state = ST_NORM2;
            end
            ST_NORM2: begin
                n_n = n_sum;
                if (n_sum == '0) begin
                    n_qr    = $signed(LIM);
                    n_qi    = '0;
                    n_ovf   = 1'b1;
                    n_state = ST_SC0;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIVR;
                end
            end
            ST_DIVR: begin
                div_den = r_n;
                div_num = {mi[XW-2:0], {FB{1'b0}}};
                if (div_done) begin
                    fa        = fix_mag(div_quot, r_pr[XW-1]);
                    n_qr      = fa.v;
                    n_ovf     = r_ovf | fa.ovf;
                    div_start = 1'b1;
                    n_state   = ST_DIVI;
                end
            end
            ST_DIVI: begin
                div_den = r_n;
                if (div_done) begin
                    fa      = fix_mag(div_quot, !r_pi[XW-1] && (r_pi != '0));
                    n_qi    = fa.v;
                    n_ovf   = r_ovf | fa.ovf;
                    n_state = ST_SC0;
                end
            end
            // x = x*(d-1)/d + q/d
            ST_SC0: n_state = ST_SC1;
            ST_SC1: begin
                n_t     = frac_scale(r_xr, mul_p, r_degree, 1'b1);
                n_state = ST_SC2;
            end
            ST_SC2: begin
                fa      = sat_add(r_t, frac_scale(r_qr, mul_p, r_degree, 1'b0));
                n_xr    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_state = ST_SC3;
            end
            ST_SC3: begin
                n_t     = frac_scale(r_xi, mul_p, r_degree, 1'b1);
                n_state = ST_SC4;
            end
            ST_SC4: begin
                fa      = sat_add(r_t, frac_scale(r_qi, mul_p, r_degree, 1'b0));
                n_xi    = fa.v;
                n_ovf   = r_ovf | fa.ovf;
                n_iter  = r_iter + 16'(r_inc);
                n_inc   = 1'b1;
                n_pt    = '0;
                n_state = ST_TEST0;
            end
            // distance to roots, then origin
            ST_TEST0: begin
                if (dr[XW-1:NB] != '0 || di[XW-1:NB] != '0) begin
                    adv = 1'b1;
                end else begin
                    n_state = ST_TEST1;
                end
            end
            ST_TEST1: begin
                n_acc   = mul_p[AW-1:0];
                n_state = ST_TEST2;
            end
            ST_TEST2: begin
                if (d2 <= {1'b0, NEAR_T}) begin
                    fin        = 1'b1;
                    fin_reason = (r_pt == r_degree[2:0]) ? RSN_ORIGIN : RSN_ROOT;
                end else begin
                    adv = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // next test point, or escape and cap checks after the origin
        if (adv) begin
            if (r_pt == r_degree[2:0]) begin
                if (r_ovf || mag(r_xr) >= {1'b0, r_esc} || mag(r_xi) >= {1'b0, r_esc}) begin
                    fin        = 1'b1;
                    fin_reason = RSN_ESCAPE;
                end else if (r_iter >= r_cap) begin
                    fin        = 1'b1;
                    fin_reason = RSN_CAP;
                end else begin
                    n_state = ST_STEP;
                end
            end else begin
                n_pt    = r_pt + 3'd1;
                n_state = ST_TEST0;
            end
        end

        // result
        if (fin) begin
            n_valid  = 1'b1;
            n_gray   = gray_of(fin_iter, r_degree);
            n_iters  = fin_iter;
            n_reason = fin_reason;
            n_state  = ST_IDLE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 4'd3;
            r_step   <= SW'(65536);
            r_cap    <= 16'd200;
            r_esc    <= 31'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEGREE: r_degree <= i_cfg_data[3:0];
                REG_STEP:   r_step   <= i_cfg_data[SW-1:0];
                REG_CAP:    r_cap    <= i_cfg_data[15:0];
                REG_ESCAPE: r_esc    <= i_cfg_data;
                default:    r_degree <= r_degree;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ovf    <= n_ovf;
        r_inc    <= n_inc;
        r_iter   <= n_iter;
        r_k      <= n_k;
        r_pt     <= n_pt;
        r_row    <= n_row;
        r_xr     <= n_xr;
        r_xi     <= n_xi;
        r_pr     <= n_pr;
        r_pi     <= n_pi;
        r_f0     <= n_f0;
        r_f1     <= n_f1;
        r_f2     <= n_f2;
        r_qr     <= n_qr;
        r_qi     <= n_qi;
        r_t      <= n_t;
        r_n      <= n_n;
        r_acc    <= n_acc;
        r_gray   <= n_gray;
        r_iters  <= n_iters;
        r_reason <= n_reason;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_gray        = r_gray;
    assign o_iterations  = r_iters;
    assign o_stop_reason = r_reason;

endmodule
`default_nettype wire

[rtl/nfp_mul.sv]
// ----------------------------------------------------------------------------
// nfp_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module nfp_mul import nfp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic [XW-1:0] i_a,
    input  wire logic [XW-1:0] i_b,
    output logic      [PW-1:0] o_p
);

    logic [PW-1:0] r_p;

    // product register
    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

[rtl/nfp_div.sv]
// ----------------------------------------------------------------------------
// nfp_div
// Restoring divider, one quotient bit per cycle, NW-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module nfp_div import nfp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic      [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_q;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_nx;

    // trial subtract
    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(NW - 1);
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= rem_nx[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire
